### hdl/iwl_pkg.sv
// Shared types and constants for the indentation whitespace lint block.
`default_nettype none

package iwl_pkg;

  localparam int unsigned LineBitsDef  = 20;
  localparam int unsigned LineOutBits  = 20;
  localparam logic [7:0]  ErrLimitRst  = 8'd3;

  localparam logic [7:0]  ByteNl       = 8'd10;
  localparam logic [7:0]  ByteTab      = 8'd9;
  localparam logic [7:0]  ByteSpace    = 8'd32;

  typedef enum logic [2:0] {
    PhEmpty      = 3'd0,
    PhSpaceLead  = 3'd1,
    PhTabs       = 3'd2,
    PhTabContent = 3'd3,
    PhPlain      = 3'd4
  } phase_e;

  typedef enum logic [2:0] {
    FindSpaceIndent = 3'd0,
    FindTabOnly     = 3'd1,
    FindMixed       = 3'd2,
    FindInnerTab    = 3'd3,
    FindTrailing    = 3'd4,
    FindSkipping    = 3'd5
  } finding_e;

endpackage

`default_nettype wire

### hdl/indent_whitespace_lint.sv
// Top level of the indentation whitespace lint block.
//
// Bytes of a text file arrive on the slave stream, one per beat: tdata holds
// the byte, tlast marks end of file (byte ignored, an unterminated last line
// is closed, per-file state cleared). Each line closed by a newline gives at
// most one finding on the master stream: tdata carries the one-based line
// number, tuser the finding code. After error_limit findings the next line
// gives a skip notice and the rest of the file is silent.
// Throughput is one byte per cycle while tready is high, and findings are
// registered. Flags and counters are updated by a single level of logic
// behind the accepting edge. A stalled receiver holds the output register;
// one further finding lands in a skid register, and tready drops only while
// the skid is full. Reset empties both registers, clears all per-file state
// and sets the error limit to 3. The limit is written by the user through
// cfg_we_i / cfg_wdata_i only while idle; the block does not enforce it.
`default_nettype none

module indent_whitespace_lint #(
  parameter int unsigned LINE_BITS = iwl_pkg::LineBitsDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] text_byte
  input  wire logic        s_axis_tlast,   // end_of_text
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,   // [19:0] line_no, [23:20] zero
  output logic [2:0]       m_axis_tuser,   // [2:0] finding
  input  wire logic        cfg_we_i,
  input  wire logic [7:0]  cfg_wdata_i     // error_limit
);
  import iwl_pkg::*;

  logic [7:0]           err_limit_q;
  logic [LINE_BITS-1:0] line_cnt_q, line_cnt_d, line_next;
  logic [7:0]           err_cnt_q, err_cnt_d;
  logic                 stopped_q, stopped_d;
  phase_e               phase_q, phase_d;
  logic                 sp_after_q, sp_after_d;
  logic                 tab_in_q, tab_in_d;
  logic                 blank_q, blank_d;

  logic                 out_vld_q, out_vld_d;
  logic [LineOutBits-1:0] out_line_q, out_line_d;
  finding_e             out_find_q, out_find_d;
  logic                 skid_vld_q, skid_vld_d;
  logic [LineOutBits-1:0] skid_line_q, skid_line_d;
  finding_e             skid_find_q, skid_find_d;

  logic                 in_beat, pop, is_nl, is_tab, is_space, close;
  logic                 code_vld, res_vld;
  finding_e             code, res_find;
  logic [LineOutBits-1:0] res_line;
  logic [LINE_BITS+LineOutBits-1:0] line_ext;

  assign in_beat  = s_axis_tvalid && s_axis_tready;
  assign pop      = out_vld_q && m_axis_tready;
  assign is_nl    = (s_axis_tdata == ByteNl);
  assign is_tab   = (s_axis_tdata == ByteTab);
  assign is_space = (s_axis_tdata == ByteSpace);
  assign close    = s_axis_tlast ? (phase_q != PhEmpty) : is_nl;
  assign line_next = (&line_cnt_q) ? line_cnt_q : line_cnt_q + 1'b1;
  assign line_ext  = {{LineOutBits{1'b0}}, line_next};

  // line shape tracking
  always_comb begin
    phase_d    = phase_q;
    sp_after_d = sp_after_q;
    tab_in_d   = tab_in_q;
    blank_d    = blank_q;
    if (in_beat) begin
      if (close || s_axis_tlast) begin
        phase_d    = PhEmpty;
        sp_after_d = 1'b0;
        tab_in_d   = 1'b0;
        blank_d    = 1'b0;
      end else begin
        unique case (phase_q)
          PhEmpty: begin
            phase_d = is_space ? PhSpaceLead : (is_tab ? PhTabs : PhPlain);
          end
          PhTabs: begin
            if (!is_tab) begin
              phase_d    = PhTabContent;
              sp_after_d = is_space;
            end
          end
          PhTabContent: begin
            if (is_tab) tab_in_d = 1'b1;
          end
          default: ;
        endcase
        blank_d = is_tab || is_space;
      end
    end
  end

  // finding for the line being closed
  always_comb begin
    code_vld = 1'b0;
    code     = FindTrailing;
    unique case (phase_q)
      PhSpaceLead: begin
        code_vld = 1'b1;
        code     = FindSpaceIndent;
      end
      PhTabs: begin
        code_vld = 1'b1;
        code     = FindTabOnly;
      end
      PhTabContent: begin
        priority if (sp_after_q) begin
          code_vld = 1'b1;
          code     = FindMixed;
        end else if (tab_in_q) begin
          code_vld = 1'b1;
          code     = FindInnerTab;
        end else begin
          code_vld = blank_q;
        end
      end
      PhPlain: code_vld = blank_q;
      default: ;
    endcase
  end

  // counters and result
  always_comb begin
    line_cnt_d = line_cnt_q;
    err_cnt_d  = err_cnt_q;
    stopped_d  = stopped_q;
    res_vld    = 1'b0;
    res_find   = code;
    res_line   = line_ext[LineOutBits-1:0];
    if (in_beat && close && !stopped_q) begin
      if (err_cnt_q >= err_limit_q) begin
        stopped_d = 1'b1;
        res_vld   = 1'b1;
        res_find  = FindSkipping;
      end else begin
        line_cnt_d = line_next;
        if (code_vld) begin
          res_vld = 1'b1;
          if (!(&err_cnt_q)) err_cnt_d = err_cnt_q + 8'd1;
        end
      end
    end
    if (in_beat && s_axis_tlast) begin
      line_cnt_d = '0;
      err_cnt_d  = '0;
      stopped_d  = 1'b0;
    end
  end

  // output register and skid register
  always_comb begin
    out_vld_d   = out_vld_q;
    out_line_d  = out_line_q;
    out_find_d  = out_find_q;
    skid_vld_d  = skid_vld_q;
    skid_line_d = skid_line_q;
    skid_find_d = skid_find_q;
    if (skid_vld_q) begin
      if (pop) begin
        out_line_d = skid_line_q;
        out_find_d = skid_find_q;
        skid_vld_d = 1'b0;
      end
    end else if (res_vld) begin
      if (!out_vld_q || pop) begin
        out_vld_d  = 1'b1;
        out_line_d = res_line;
        out_find_d = res_find;
      end else begin
        skid_vld_d  = 1'b1;
        skid_line_d = res_line;
        skid_find_d = res_find;
      end
    end else if (pop) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      err_limit_q <= ErrLimitRst;
      line_cnt_q  <= '0;
      err_cnt_q   <= '0;
      stopped_q   <= 1'b0;
      phase_q     <= PhEmpty;
      sp_after_q  <= 1'b0;
      tab_in_q    <= 1'b0;
      blank_q     <= 1'b0;
      out_vld_q   <= 1'b0;
      skid_vld_q  <= 1'b0;
    end else begin
      if (cfg_we_i) err_limit_q <= cfg_wdata_i;
      line_cnt_q <= line_cnt_d;
      err_cnt_q  <= err_cnt_d;
      stopped_q  <= stopped_d;
      phase_q    <= phase_d;
      sp_after_q <= sp_after_d;
      tab_in_q   <= tab_in_d;
      blank_q    <= blank_d;
      out_vld_q  <= out_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_line_q  <= out_line_d;
    out_find_q  <= out_find_d;
    skid_line_q <= skid_line_d;
    skid_find_q <= skid_find_d;
  end

  assign s_axis_tready = !skid_vld_q;
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {{(24-LineOutBits){1'b0}}, out_line_q};
  assign m_axis_tuser  = out_find_q;

endmodule

`default_nettype wire

### hdl/iwl_checker.sv
// Port-level checker for the indentation whitespace lint block, with its bind.
`default_nettype none

module iwl_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic [7:0]  s_axis_tdata,
  input wire logic        s_axis_tlast,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [23:0] m_axis_tdata,
  input wire logic [2:0]  m_axis_tuser
);
  import iwl_pkg::*;

  // a held finding beat keeps its contents
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("finding beat changed while stalled");

  // back-pressure only once the output register is occupied
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with empty output");

  // a content byte never produces a finding
  a_content: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid && s_axis_tvalid && s_axis_tready && !s_axis_tlast &&
      (s_axis_tdata != ByteNl) |=> !m_axis_tvalid)
    else $error("finding without end of line");

  // no finding appears without an input beat
  a_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid && !(s_axis_tvalid && s_axis_tready) |=> !m_axis_tvalid)
    else $error("finding appeared from nowhere");

endmodule

bind indent_whitespace_lint iwl_checker u_iwl_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tlast  (s_axis_tlast),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
